// ----- hw/rtl/pebrp_pkg.sv -----
// Shared types and constants for the PE base-relocation directory parser.
// No dependencies; used by pe_base_relocation_parser_top.
package pebrp_pkg;

    localparam int unsigned WORD_W = 32;

    // Directory block header length in bytes
    localparam logic [WORD_W-1:0] HDR_BYTES   = 32'd8;
    localparam logic [WORD_W-1:0] HW_BYTES    = 32'd2;
    // Bytes of the header already taken when its last halfword arrives
    localparam logic [WORD_W-1:0] HDR_PRE     = 32'd6;
    localparam logic [WORD_W:0]   NEED_NARROW = 33'd4;
    localparam logic [WORD_W:0]   NEED_WIDE   = 33'd8;

    // Configuration register indexes
    localparam logic CFG_DIR_SIZE  = 1'b0;
    localparam logic CFG_IMG_LIMIT = 1'b1;

    // Relocation entry types
    localparam logic [3:0] TYPE_PAD     = 4'd0;
    localparam logic [3:0] TYPE_HIGHLOW = 4'd3;
    localparam logic [3:0] TYPE_DIR64   = 4'd10;

    typedef enum logic [2:0] {
        PH_PAGE_LO = 3'd0,
        PH_PAGE_HI = 3'd1,
        PH_SIZE_LO = 3'd2,
        PH_SIZE_HI = 3'd3,
        PH_ENTRIES = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_RECORD  = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_BADSIZE = 3'd2,
        ST_OUTSIDE = 3'd3,
        ST_BADTYPE = 3'd4,
        ST_DONE    = 3'd5
    } t_status;

    typedef struct packed {
        logic              valid;
        t_status           status;
        logic              wide;
        logic [WORD_W-1:0] target;
        logic [WORD_W-1:0] index;
        logic              last;
    } t_result;

endpackage

// ----- hw/rtl/pe_base_relocation_parser_top.sv -----
// PE base-relocation directory parser, top level.
// Depends on pebrp_pkg for phase/status types and constants.
//
// Usage:
//   Write dir_size (index 0) and the image bound (index 1) through the cfg
//   port while idle, then stream the directory one little-endian halfword per
//   beat on the input channel (i_in_valid / o_in_stall / i_half_word).
//   Each beat yields zero or one result beat on the output channel
//   (o_out_valid / i_out_stall / o_status ... o_last): a record for each
//   type 3 or type 10 entry, an error status, or a final done status.
//   A result appears on the outputs in the cycle after its input beat is
//   taken. Throughput: one halfword per cycle while o_in_stall is low,
//   with a single header/entry decode stage feeding the result register.
//   When the receiver stalls a pending result, the input channel is stalled
//   only if a result is still held; beats may otherwise keep flowing.
//   Errors are sticky: after an error or a completed directory all further
//   halfwords are taken and dropped without results.
//   Reset (synchronous, active low) clears parser state, both config
//   registers and the result register valid.
module pe_base_relocation_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_half_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic        o_wide_target,
    output logic [31:0] o_target_offset,
    output logic [31:0] o_record_index,
    output logic        o_last
);

    logic [31:0]        r_dir_size;
    logic [31:0]        r_img_limit;
    pebrp_pkg::t_phase  r_phase,   n_phase;
    logic [31:0]        r_page,    n_page;
    logic [15:0]        r_size_lo, n_size_lo;
    logic [30:0]        r_entries, n_entries;
    logic [31:0]        r_bytes,   n_bytes;
    logic [31:0]        r_records, n_records;
    logic               r_failed,  n_failed;
    pebrp_pkg::t_result r_out,     n_out;

    logic        in_take;
    logic        out_take;
    logic        at_first;
    logic        take;
    logic [31:0] remain;
    logic [31:0] bytes_inc;
    logic [31:0] bsize;
    logic [31:0] blk_rem;
    logic [31:0] blk_area;
    logic [30:0] blk_entries;
    logic        bad_size;
    logic [30:0] ent_dec;
    logic        dir_end;
    logic [3:0]  etype;
    logic        supported;
    logic        wide;
    logic [31:0] target;
    logic [32:0] target_end;
    logic        outside;

    assign o_in_stall = r_out.valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = r_out.valid && !i_out_stall;

    // Phases 5..7 never occur; treat anything else as a first header halfword
    assign at_first = (r_phase != pebrp_pkg::PH_PAGE_HI) && (r_phase != pebrp_pkg::PH_SIZE_LO)
                   && (r_phase != pebrp_pkg::PH_SIZE_HI) && (r_phase != pebrp_pkg::PH_ENTRIES);
    assign take = in_take && !r_failed && !(at_first && (r_bytes >= r_dir_size));

    assign remain    = r_dir_size - r_bytes;
    assign bytes_inc = r_bytes + pebrp_pkg::HW_BYTES;

    // Block size check on the last header halfword
    assign bsize       = {i_half_word, r_size_lo};
    assign blk_rem     = r_dir_size - (r_bytes - pebrp_pkg::HDR_PRE);
    assign blk_area    = bsize - pebrp_pkg::HDR_BYTES;
    assign blk_entries = blk_area[31:1];
    assign bad_size    = (bsize < pebrp_pkg::HDR_BYTES) || (bsize > blk_rem) || bsize[0];

    // Entry decode
    assign ent_dec    = r_entries - 31'd1;
    assign dir_end    = (ent_dec == 31'd0) && (bytes_inc >= r_dir_size);
    assign etype      = i_half_word[15:12];
    assign supported  = (etype == pebrp_pkg::TYPE_HIGHLOW) || (etype == pebrp_pkg::TYPE_DIR64);
    assign wide       = (etype == pebrp_pkg::TYPE_DIR64);
    assign target     = r_page + {20'd0, i_half_word[11:0]};
    assign target_end = {1'b0, target} + (wide ? pebrp_pkg::NEED_WIDE : pebrp_pkg::NEED_NARROW);
    assign outside    = target_end > {1'b0, r_img_limit};

    // Next parser state
    always_comb begin
        n_phase   = r_phase;
        n_page    = r_page;
        n_size_lo = r_size_lo;
        n_entries = r_entries;
        n_bytes   = r_bytes;
        n_records = r_records;
        n_failed  = r_failed;
        if (take) begin
            case (r_phase)
                pebrp_pkg::PH_PAGE_HI: begin
                    n_page  = {i_half_word, r_page[15:0]};
                    n_phase = pebrp_pkg::PH_SIZE_LO;
                    n_bytes = bytes_inc;
                end
                pebrp_pkg::PH_SIZE_LO: begin
                    n_size_lo = i_half_word;
                    n_phase   = pebrp_pkg::PH_SIZE_HI;
                    n_bytes   = bytes_inc;
                end
                pebrp_pkg::PH_SIZE_HI: begin
                    if (bad_size) begin
                        n_failed = 1'b1;
                    end else begin
                        n_bytes   = bytes_inc;
                        n_entries = blk_entries;
                        n_phase   = (blk_entries != 31'd0) ? pebrp_pkg::PH_ENTRIES
                                                           : pebrp_pkg::PH_PAGE_LO;
                    end
                end
                pebrp_pkg::PH_ENTRIES: begin
                    n_entries = ent_dec;
                    n_bytes   = bytes_inc;
                    if (ent_dec == 31'd0) begin
                        n_phase = pebrp_pkg::PH_PAGE_LO;
                    end
                    if (etype != pebrp_pkg::TYPE_PAD) begin
                        if (!supported || outside) begin
                            n_failed = 1'b1;
                        end else begin
                            n_records = r_records + 32'd1;
                        end
                    end
                end
                default: begin
                    // first header halfword: page RVA low
                    if (remain < pebrp_pkg::HDR_BYTES) begin
                        n_failed = 1'b1;
                    end else begin
                        n_page  = {16'd0, i_half_word};
                        n_phase = pebrp_pkg::PH_PAGE_HI;
                        n_bytes = bytes_inc;
                    end
                end
            endcase
        end
    end

    // Result for this beat
    always_comb begin
        n_out.valid  = 1'b0;
        n_out.status = pebrp_pkg::ST_DONE;
        n_out.wide   = 1'b0;
        n_out.target = 32'd0;
        n_out.index  = r_records;
        n_out.last   = 1'b1;
        if (take) begin
            case (r_phase)
                pebrp_pkg::PH_PAGE_HI, pebrp_pkg::PH_SIZE_LO: begin
                    n_out.valid = 1'b0;
                end
                pebrp_pkg::PH_SIZE_HI: begin
                    if (bad_size) begin
                        n_out.valid  = 1'b1;
                        n_out.status = pebrp_pkg::ST_BADSIZE;
                    end else if ((blk_entries == 31'd0) && (bytes_inc >= r_dir_size)) begin
                        n_out.valid  = 1'b1;
                        n_out.status = pebrp_pkg::ST_DONE;
                    end
                end
                pebrp_pkg::PH_ENTRIES: begin
                    if (etype == pebrp_pkg::TYPE_PAD) begin
                        n_out.valid  = dir_end;
                        n_out.status = pebrp_pkg::ST_DONE;
                    end else if (!supported) begin
                        n_out.valid  = 1'b1;
                        n_out.status = pebrp_pkg::ST_BADTYPE;
                    end else if (outside) begin
                        n_out.valid  = 1'b1;
                        n_out.status = pebrp_pkg::ST_OUTSIDE;
                        n_out.wide   = wide;
                        n_out.target = target;
                    end else begin
                        n_out.valid  = 1'b1;
                        n_out.status = pebrp_pkg::ST_RECORD;
                        n_out.wide   = wide;
                        n_out.target = target;
                        n_out.last   = dir_end;
                    end
                end
                default: begin
                    if (remain < pebrp_pkg::HDR_BYTES) begin
                        n_out.valid  = 1'b1;
                        n_out.status = pebrp_pkg::ST_NOFIT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_size  <= 32'd0;
            r_img_limit <= 32'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                pebrp_pkg::CFG_DIR_SIZE:  r_dir_size  <= i_cfg_data;
                pebrp_pkg::CFG_IMG_LIMIT: r_img_limit <= i_cfg_data;
                default:                  r_dir_size  <= r_dir_size;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= pebrp_pkg::PH_PAGE_LO;
            r_page    <= 32'd0;
            r_size_lo <= 16'd0;
            r_entries <= 31'd0;
            r_bytes   <= 32'd0;
            r_records <= 32'd0;
            r_failed  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_page    <= n_page;
            r_size_lo <= n_size_lo;
            r_entries <= n_entries;
            r_bytes   <= n_bytes;
            r_records <= n_records;
            r_failed  <= n_failed;
        end
    end

    // Result register: loads on a new result, drains when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (n_out.valid) begin
            r_out <= n_out;
        end else if (out_take) begin
            r_out.valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out.valid;
    assign o_status        = r_out.status;
    assign o_wide_target   = r_out.wide;
    assign o_target_offset = r_out.target;
    assign o_record_index  = r_out.index;
    assign o_last          = r_out.last;

    // Once failed, no fresh result may appear
    a_no_result_after_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_failed && !o_out_valid) |=> !o_out_valid)
        else $error("result produced after sticky error");

    // Only a record may leave the directory open
    a_open_is_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_status == pebrp_pkg::ST_RECORD))
        else $error("non-record result without last");

    // An error result implies the sticky flag is set
    a_error_sets_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != pebrp_pkg::ST_RECORD)
         && (o_status != pebrp_pkg::ST_DONE)) |-> r_failed)
        else $error("error reported without sticky flag");

    // Records are numbered in order
    a_record_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out.valid && (n_out.status == pebrp_pkg::ST_RECORD)) |=>
        (r_records == (o_record_index + 32'd1)))
        else $error("record counter out of step");

endmodule

// ----- sim/tb_pe_base_relocation_parser_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for pe_base_relocation_parser_top: streams relocation
// directories, predicts every result beat and checks them in order.
// Depends on pebrp_pkg and the RTL top level only.
module tb;

    localparam int IDLE_PCT     = 35;
    localparam int HOLD_CYCLES  = 120;
    localparam int SETTLE       = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 430;

    typedef struct packed {
        pebrp_pkg::t_status status;
        logic               wide;
        logic [31:0]        target;
        logic [31:0]        index;
        logic               last;
    } t_reloc_result;

    // ways the closing directory is broken; only one error can ever be seen per run
    typedef enum int {
        BRK_NOFIT, BRK_SMALL, BRK_BIG, BRK_ODD_SIZE, BRK_OUTSIDE, BRK_BADTYPE, BRK_ODD_DIR
    } t_break_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_half_word = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic        o_wide_target;
    logic [31:0] o_target_offset;
    logic [31:0] o_record_index;
    logic        o_last;

    pe_base_relocation_parser_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_half_word    (i_half_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_wide_target  (o_wide_target),
        .o_target_offset(o_target_offset),
        .o_record_index (o_record_index),
        .o_last         (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------- parser prediction state ----------------
    logic [31:0]       dir_len, image_len;
    pebrp_pkg::t_phase parse_phase;
    logic [31:0]       page_addr, bytes_taken, records_out;
    logic [15:0]       size_lo;
    logic [30:0]       entries_todo;
    bit                parse_failed;

    t_reloc_result expected_results[$];
    logic [15:0]   hw_queue[$];
    logic [15:0]   dir_words[$];

    int            error_count = 0;
    int            cycle_count = 0;
    int            items_sent = 0;
    bit            in_taken = 1'b0;
    bit            no_idle = 1'b0;
    bit            want_hold = 1'b0;
    bit            hold_used = 1'b0;
    int            hold_left = 0;
    logic [31:0]   dir_offset = '0;
    t_reloc_result oldest;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic push_result(input pebrp_pkg::t_status st, input logic w,
                               input logic [31:0] tg, input logic [31:0] idx,
                               input logic lst);
        t_reloc_result r;
        r.status = st;
        r.wide   = w;
        r.target = tg;
        r.index  = idx;
        r.last   = lst;
        expected_results.push_back(r);
    endtask

    task automatic raise_error(input pebrp_pkg::t_status st, input logic w,
                               input logic [31:0] tg);
        parse_failed = 1'b1;
        push_result(st, w, tg, records_out, 1'b1);
    endtask

    task automatic parse_halfword(input logic [15:0] hw);
        logic [31:0] bsize, room, target;
        logic [32:0] reach;
        logic [3:0]  kind;
        logic        wide, at_end;
        if (!parse_failed
            && !(parse_phase == pebrp_pkg::PH_PAGE_LO && bytes_taken >= dir_len)) begin
            case (parse_phase)
                pebrp_pkg::PH_PAGE_LO: begin
                    if (dir_len - bytes_taken < pebrp_pkg::HDR_BYTES) begin
                        raise_error(pebrp_pkg::ST_NOFIT, 1'b0, '0);
                    end else begin
                        page_addr    = {16'h0, hw};
                        parse_phase  = pebrp_pkg::PH_PAGE_HI;
                        bytes_taken += pebrp_pkg::HW_BYTES;
                    end
                end
                pebrp_pkg::PH_PAGE_HI: begin
                    page_addr[31:16] = hw;
                    parse_phase      = pebrp_pkg::PH_SIZE_LO;
                    bytes_taken     += pebrp_pkg::HW_BYTES;
                end
                pebrp_pkg::PH_SIZE_LO: begin
                    size_lo      = hw;
                    parse_phase  = pebrp_pkg::PH_SIZE_HI;
                    bytes_taken += pebrp_pkg::HW_BYTES;
                end
                pebrp_pkg::PH_SIZE_HI: begin
                    bsize = {hw, size_lo};
                    // room left at the start of this block
                    room  = dir_len - (bytes_taken - pebrp_pkg::HDR_PRE);
                    if (bsize < pebrp_pkg::HDR_BYTES || bsize > room || bsize[0]) begin
                        raise_error(pebrp_pkg::ST_BADSIZE, 1'b0, '0);
                    end else begin
                        bytes_taken += pebrp_pkg::HW_BYTES;
                        entries_todo = 31'((bsize - pebrp_pkg::HDR_BYTES) >> 1);
                        if (entries_todo != 0) begin
                            parse_phase = pebrp_pkg::PH_ENTRIES;
                        end else begin
                            parse_phase = pebrp_pkg::PH_PAGE_LO;
                            if (bytes_taken >= dir_len)
                                push_result(pebrp_pkg::ST_DONE, 1'b0, '0, records_out, 1'b1);
                        end
                    end
                end
                default: begin
                    target = page_addr + {20'h0, hw[11:0]};
                    kind   = hw[15:12];
                    entries_todo = entries_todo - 31'd1;
                    bytes_taken += pebrp_pkg::HW_BYTES;
                    if (entries_todo == 0)
                        parse_phase = pebrp_pkg::PH_PAGE_LO;
                    at_end = (entries_todo == 0) && (bytes_taken >= dir_len);
                    if (kind == pebrp_pkg::TYPE_PAD) begin
                        if (at_end)
                            push_result(pebrp_pkg::ST_DONE, 1'b0, '0, records_out, 1'b1);
                    end else if (kind != pebrp_pkg::TYPE_HIGHLOW
                                 && kind != pebrp_pkg::TYPE_DIR64) begin
                        raise_error(pebrp_pkg::ST_BADTYPE, 1'b0, '0);
                    end else begin
                        wide  = (kind == pebrp_pkg::TYPE_DIR64);
                        reach = {1'b0, target}
                              + (wide ? pebrp_pkg::NEED_WIDE : pebrp_pkg::NEED_NARROW);
                        if (reach > {1'b0, image_len}) begin
                            raise_error(pebrp_pkg::ST_OUTSIDE, wide, target);
                        end else begin
                            push_result(pebrp_pkg::ST_RECORD, wide, target, records_out,
                                        at_end);
                            records_out = records_out + 32'd1;
                        end
                    end
                end
            endcase
        end
    endtask

    // ---------------- monitor: config tracking, result check, prediction ----------------
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** pe_base_relocation_parser_top: FAILED **");
            $finish;
        end else begin
            in_taken = 1'b0;
            if (!i_rst_n) begin
                dir_len      = '0;
                image_len    = '0;
                parse_phase  = pebrp_pkg::PH_PAGE_LO;
                page_addr    = '0;
                size_lo      = '0;
                entries_todo = '0;
                bytes_taken  = '0;
                records_out  = '0;
                parse_failed = 1'b0;
            end else begin
                if (i_cfg_wr_en) begin
                    if (i_cfg_index == pebrp_pkg::CFG_DIR_SIZE)
                        dir_len = i_cfg_data;
                    else
                        image_len = i_cfg_data;
                end
                if (o_out_valid && !i_out_stall) begin
                    if (expected_results.size() == 0) begin
                        report_mismatch($sformatf("unexpected result, status %0d", o_status));
                    end else begin
                        oldest = expected_results.pop_front();
                        if (o_status !== oldest.status)
                            report_mismatch($sformatf("status %0d, want %0d",
                                                      o_status, oldest.status));
                        if (o_wide_target !== oldest.wide)
                            report_mismatch($sformatf("wide_target %0b, want %0b",
                                                      o_wide_target, oldest.wide));
                        if (o_target_offset !== oldest.target)
                            report_mismatch($sformatf("target_offset %h, want %h",
                                                      o_target_offset, oldest.target));
                        if (o_record_index !== oldest.index)
                            report_mismatch($sformatf("record_index %0d, want %0d",
                                                      o_record_index, oldest.index));
                        if (o_last !== oldest.last)
                            report_mismatch($sformatf("last %0b, want %0b",
                                                      o_last, oldest.last));
                    end
                end
                if (i_in_valid && !o_in_stall) begin
                    in_taken = 1'b1;
                    parse_halfword(i_half_word);
                end
            end
        end
    end

    // ---------------- input driver ----------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (hw_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_in_valid  <= 1'b1;
                i_half_word <= hw_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver stall ----------------
    always @(negedge i_clk) begin
        if (want_hold && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (no_idle) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // all beats taken, all results seen, then let the result register drain
    task automatic wait_idle();
        do @(posedge i_clk); while (hw_queue.size() != 0 || i_in_valid);
        do @(negedge i_clk); while (expected_results.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_page(input logic [31:0] img);
        return $urandom_range(0, img - 32'h1008);
    endfunction

    function automatic logic [15:0] good_entry(input bit records_only);
        int pick;
        pick = $urandom_range(0, 9);
        if (!records_only && pick < 2)
            return {pebrp_pkg::TYPE_PAD, 12'($urandom)};
        return {(pick % 2 == 0) ? pebrp_pkg::TYPE_HIGHLOW : pebrp_pkg::TYPE_DIR64,
                12'($urandom)};
    endfunction

    task automatic stage_header(input logic [31:0] page, input logic [31:0] bsize);
        dir_words.push_back(page[15:0]);
        dir_words.push_back(page[31:16]);
        dir_words.push_back(bsize[15:0]);
        dir_words.push_back(bsize[31:16]);
    endtask

    task automatic stage_block(input logic [31:0] page, input int n_ent, input bit records_only);
        stage_header(page, pebrp_pkg::HDR_BYTES + 32'(2 * n_ent));
        repeat (n_ent) dir_words.push_back(good_entry(records_only));
    endtask

    // program both registers, stream the staged words plus trailing ignored noise
    task automatic commit_phase(input logic [31:0] dir_val, input logic [31:0] img,
                                input int noise);
        write_reg(pebrp_pkg::CFG_DIR_SIZE, dir_val);
        write_reg(pebrp_pkg::CFG_IMG_LIMIT, img);
        foreach (dir_words[k]) hw_queue.push_back(dir_words[k]);
        dir_words.delete();
        repeat (noise) hw_queue.push_back(16'($urandom));
        wait_idle();
    endtask

    // ---------------- sequence ----------------
    initial begin
        logic [31:0] img, dir_val, page, bad_t;
        logic [11:0] off12;
        logic [3:0]  ty;
        logic        w;
        int          phase_no, n_blk;
        t_break_kind brk;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directory length zero after reset: everything is dropped
        hw_queue.push_back(16'hFFFF);
        hw_queue.push_back(16'h0000);
        hw_queue.push_back(16'hA5A5);
        wait_idle();

        // directed: records at the top of the address space, wrapping targets,
        // an empty block in the middle, directory ending on a record
        stage_header(32'hFFFF_FF00, 32'd18);
        dir_words.push_back({pebrp_pkg::TYPE_HIGHLOW, 12'h0FB});
        dir_words.push_back({pebrp_pkg::TYPE_DIR64, 12'h0F7});
        dir_words.push_back({pebrp_pkg::TYPE_DIR64, 12'h200});
        dir_words.push_back({pebrp_pkg::TYPE_HIGHLOW, 12'hFFF});
        dir_words.push_back({pebrp_pkg::TYPE_PAD, 12'hFFF});
        stage_header(32'h0000_1000, pebrp_pkg::HDR_BYTES);
        stage_header(32'h0000_0000, 32'd12);
        dir_words.push_back({pebrp_pkg::TYPE_DIR64, 12'h000});
        dir_words.push_back({pebrp_pkg::TYPE_HIGHLOW, 12'h800});
        items_sent += dir_words.size();
        dir_val = dir_offset + 32'(2 * dir_words.size());
        dir_offset = dir_val;
        commit_phase(dir_val, 32'hFFFF_FFFF, 2);

        // random well-formed directories chained by growing the directory length
        phase_no = 0;
        while (items_sent < RANDOM_ITEMS) begin
            no_idle   = (phase_no == 1);
            want_hold = (phase_no == 3);
            img = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                              : $urandom_range(32'hFFFF_FFFE, 32'h2000);
            if (phase_no == 3) begin
                stage_block(pick_page(img), 60, 1'b1);
            end else begin
                n_blk = (phase_no == 1) ? 4 : $urandom_range(1, 4);
                repeat (n_blk)
                    stage_block(pick_page(img),
                                (phase_no == 1) ? $urandom_range(8, 16) : $urandom_range(0, 10),
                                1'b0);
            end
            items_sent += dir_words.size();
            dir_val = dir_offset + 32'(2 * dir_words.size());
            dir_offset = dir_val;
            commit_phase(dir_val, img, $urandom_range(0, 2));
            phase_no++;
        end
        no_idle   = 1'b0;
        want_hold = 1'b0;

        // closing directory: a good block unless the image bound is zero, then one broken piece, then noise
        brk = t_break_kind'($urandom_range(0, 6));
        img = 32'hFFFF_FFFF;
        dir_val = 32'hFFFF_FFFF;
        if (brk == BRK_OUTSIDE)
            img = ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom_range(32'hFFFF_FFF0, 32'h2000);
        if (img != 0)
            stage_block(pick_page(img), $urandom_range(0, 6), 1'b0);
        page = pick_page(32'hFFFF_FFFF);
        case (brk)
            BRK_NOFIT: begin
                dir_val = dir_offset + 32'(2 * dir_words.size()) + 32'd6;
                dir_words.push_back(page[15:0]);
            end
            BRK_ODD_DIR: begin
                dir_val = dir_offset + 32'(2 * dir_words.size())
                        + 32'(2 * $urandom_range(0, 3) + 1);
                stage_header(page, pebrp_pkg::HDR_BYTES);
            end
            BRK_SMALL:    stage_header(page, $urandom_range(0, 7));
            BRK_BIG:      stage_header(page, 32'hFFFF_FFFE);
            BRK_ODD_SIZE: begin
                stage_header(page, 32'(9 + 2 * $urandom_range(0, 5)));
                dir_words.push_back(good_entry(1'b1));
            end
            BRK_OUTSIDE: begin
                w  = 1'($urandom_range(0, 1));
                ty = w ? pebrp_pkg::TYPE_DIR64 : pebrp_pkg::TYPE_HIGHLOW;
                if (img == 0) begin
                    stage_header(page, 32'd10);
                    dir_words.push_back({ty, 12'($urandom)});
                end else begin
                    // first target just fits, the next one is a byte past the image
                    bad_t = img - (w ? 32'd8 : 32'd4) + 32'd1;
                    off12 = 12'($urandom_range(1, 12'hFFF));
                    stage_header(bad_t - {20'h0, off12}, 32'd12);
                    dir_words.push_back({ty, off12 - 12'd1});
                    dir_words.push_back({ty, off12});
                end
            end
            default: begin
                do ty = 4'($urandom_range(1, 15));
                while (ty == pebrp_pkg::TYPE_HIGHLOW || ty == pebrp_pkg::TYPE_DIR64);
                stage_header(page, 32'd14);
                dir_words.push_back(good_entry(1'b1));
                dir_words.push_back(good_entry(1'b0));
                dir_words.push_back({ty, 12'($urandom)});
            end
        endcase
        commit_phase(dir_val, img, 8);

        repeat (20) @(negedge i_clk);
        if (error_count == 0)
            $display("** pe_base_relocation_parser_top: PASSED **");
        else
            $display("** pe_base_relocation_parser_top: FAILED **");
        $finish;
    end

endmodule
